/* sv/sliding_window_median_defines.svh */
// Assertion macros shared by the sliding window median checker.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sliding_window_median: check failed");

// Consequent checked in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sliding_window_median: check failed");

`endif

/* sv/swm_pkg.sv */
// Package with constants, types and helpers of the sliding window median filter.
`default_nettype none

package swm_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_WINDOW   = 64;
    localparam int DEF_SAMPLE_WIDTH = 32;

    // Width of the window size write data and the window size after reset.
    localparam int CFG_WIDTH    = 7;
    localparam int RESET_WINDOW = 3;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic clear;   // drop all held samples
        logic load;    // a word is accepted: insert, and evict when full
        logic full;    // window is full, so the oldest sample leaves
    } t_cell_ctl;

    // Status a cell shows to its neighbors.
    typedef struct packed {
        logic valid;   // cell holds a sample
        logic gt;      // empty, or holds a sample greater than the new one
    } t_cell_stat;

    // Window size actually used: zero acts as one, large values saturate.
    function automatic int eff_window(logic [CFG_WIDTH-1:0] size, int max_w);
        int w;
        w = int'(size);
        if (w == 0) begin
            return 1;
        end
        if (w > max_w) begin
            return max_w;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/swm_cell.sv */
// One cell of the sorted chain: holds a sample, its age and a valid flag.
`default_nettype none

module swm_cell #(
    parameter int SAMPLE_W = swm_pkg::DEF_SAMPLE_WIDTH,
    parameter int AGE_W    = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire swm_pkg::t_cell_ctl  i_ctl,
    input  wire logic [SAMPLE_W-1:0] i_new_key,
    input  wire logic [AGE_W-1:0]    i_oldest_age,
    input  wire logic                i_pick,
    // Lower neighbor (smaller values).
    input  wire swm_pkg::t_cell_stat i_lo_stat,
    input  wire logic [SAMPLE_W-1:0] i_lo_key,
    input  wire logic [AGE_W-1:0]    i_lo_age,
    input  wire logic                i_del_below,
    // Upper neighbor (larger values).
    input  wire swm_pkg::t_cell_stat i_hi_stat,
    input  wire logic [SAMPLE_W-1:0] i_hi_key,
    input  wire logic [AGE_W-1:0]    i_hi_age,
    // Own state toward the neighbors.
    output swm_pkg::t_cell_stat      o_stat,
    output logic [SAMPLE_W-1:0]      o_key,
    output logic [AGE_W-1:0]         o_age,
    output logic                     o_del_upto,
    // Own sample when picked as the median, else zero.
    output logic [SAMPLE_W-1:0]      o_tap
);
    import swm_pkg::*;

    logic                r_valid;
    logic [SAMPLE_W-1:0] r_key;
    logic [AGE_W-1:0]    r_age;
    logic                n_valid;
    logic [SAMPLE_W-1:0] n_key;
    logic [AGE_W-1:0]    n_age;

    logic                own_gt;
    logic                del_here;
    t_cell_stat          here_stat;
    logic [SAMPLE_W-1:0] here_key;
    logic [AGE_W-1:0]    here_age;
    t_cell_stat          lo_stat;
    logic [SAMPLE_W-1:0] lo_key;
    logic [AGE_W-1:0]    lo_age;

    // Compare against the new sample and spot the sample that is leaving.
    assign own_gt     = !r_valid || ($signed(r_key) > $signed(i_new_key));
    assign del_here   = i_ctl.full && r_valid && (r_age == i_oldest_age);
    assign o_del_upto = i_del_below | del_here;

    assign o_stat = '{valid: r_valid, gt: own_gt};
    assign o_key  = r_key;
    assign o_age  = r_age;
    assign o_tap  = i_pick ? r_key : '0;

    // View of this place and the one below after the eviction has closed the gap.
    always_comb begin
        if (o_del_upto) begin
            here_stat = i_hi_stat;
            here_key  = i_hi_key;
            here_age  = i_hi_age;
        end else begin
            here_stat = o_stat;
            here_key  = r_key;
            here_age  = r_age;
        end
        if (i_del_below) begin
            lo_stat = o_stat;
            lo_key  = r_key;
            lo_age  = r_age;
        end else begin
            lo_stat = i_lo_stat;
            lo_key  = i_lo_key;
            lo_age  = i_lo_age;
        end
    end

    // Insert: shift up if the value below is larger, take the new sample at the
    // first place whose value is larger, otherwise keep the compacted value.
    always_comb begin
        if (lo_stat.gt) begin
            n_valid = lo_stat.valid;
            n_key   = lo_key;
            n_age   = lo_age + AGE_W'(1);
        end else if (here_stat.gt) begin
            n_valid = 1'b1;
            n_key   = i_new_key;
            n_age   = '0;
        end else begin
            n_valid = here_stat.valid;
            n_key   = here_key;
            n_age   = here_age + AGE_W'(1);
        end
    end

    // Valid flag is control state; key and age are payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key <= n_key;
            r_age <= n_age;
        end
    end

endmodule

`default_nettype wire

/* sv/sliding_window_median.sv */
// Sliding window median filter: top level with the cell chain and stream control.
//
// Usage:
//   Samples arrive on the slave stream (i_s_tvalid / o_s_tready / i_s_tdata),
//   medians leave on the master stream (o_m_tvalid / i_m_tready / o_m_tdata).
//   A word moves on a channel at a rising edge where tvalid and tready are high.
//   The window size is written through i_cfg_we / i_cfg_wdata while the block is
//   idle; a write also empties the window. Zero acts as one, values above
//   MAX_WINDOW saturate.
//   Until the window has filled, an input word gives no output word; after that
//   every input word gives one: the median, the lower middle for an even window.
//   The cells take each accepted word and the pending flag marks its median,
//   which then moves to the output register, driving o_m_tdata with o_m_tvalid
//   high. One word per cycle is taken while o_s_tready is high. Each sample sits
//   in one cell of a sorted chain; all cells evict, shift and insert in the same
//   cycle. Reset empties the window and sets the window size to three.
//   When the receiver stalls, one finished median waits in the output register
//   and one more behind it; o_s_tready then drops until the output moves.
`default_nettype none

module sliding_window_median #(
    parameter int MAX_WINDOW   = swm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration: window size.
    input  wire logic                              i_cfg_we,
    input  wire logic [swm_pkg::CFG_WIDTH-1:0]     i_cfg_wdata,
    // Slave stream. tdata: sample (bits SAMPLE_WIDTH-1:0), zero padding above.
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // Master stream. tdata: median (bits SAMPLE_WIDTH-1:0), zero padding above.
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      o_m_tdata
);
    import swm_pkg::*;

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int AGE_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // Window settings and fill state.
    logic [CNT_W-1:0]        r_win;
    logic [CNT_W-1:0]        r_fill;
    logic [AGE_W-1:0]        r_oldest_age;
    logic [AGE_W-1:0]        r_med;
    // Result waiting for the output register, and the output register.
    logic                    r_pend;
    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out;

    logic                    full;
    logic                    gives_result;
    logic                    accept;
    logic                    out_free;
    logic [SAMPLE_WIDTH-1:0] new_key;
    logic [SAMPLE_WIDTH-1:0] tap_or;
    int                      cfg_win;
    t_cell_ctl               ctl;

    // Chain wiring, one entry per cell.
    t_cell_stat              w_stat [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] w_key  [MAX_WINDOW];
    logic [AGE_W-1:0]        w_age  [MAX_WINDOW];
    logic                    w_del  [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] w_tap  [MAX_WINDOW];

    assign new_key      = i_s_tdata[SAMPLE_WIDTH-1:0];
    assign full         = (r_fill == r_win);
    assign gives_result = full || ((r_fill + CNT_W'(1)) == r_win);
    assign out_free     = !r_out_valid || i_m_tready;
    assign o_s_tready   = !(r_pend && !out_free);
    assign accept       = i_s_tvalid && o_s_tready;
    assign cfg_win      = eff_window(i_cfg_wdata, MAX_WINDOW);

    assign ctl = '{clear: i_cfg_we, load: accept, full: full};

    // Window size, fill count and derived indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= CNT_W'(eff_window(CFG_WIDTH'(RESET_WINDOW), MAX_WINDOW));
            r_oldest_age <= AGE_W'(eff_window(CFG_WIDTH'(RESET_WINDOW), MAX_WINDOW) - 1);
            r_med        <= AGE_W'((eff_window(CFG_WIDTH'(RESET_WINDOW), MAX_WINDOW) - 1) / 2);
            r_fill       <= '0;
        end else if (i_cfg_we) begin
            r_win        <= CNT_W'(cfg_win);
            r_oldest_age <= AGE_W'(cfg_win - 1);
            r_med        <= AGE_W'((cfg_win - 1) >> 1);
            r_fill       <= '0;
        end else if (accept && !full) begin
            r_fill <= r_fill + CNT_W'(1);
        end
    end

    // The chain of sorted cells.
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        t_cell_stat              lo_stat;
        logic [SAMPLE_WIDTH-1:0] lo_key;
        logic [AGE_W-1:0]        lo_age;
        logic                    lo_del;
        t_cell_stat              hi_stat;
        logic [SAMPLE_WIDTH-1:0] hi_key;
        logic [AGE_W-1:0]        hi_age;

        if (i == 0) begin : g_lo_end
            assign lo_stat = '{valid: 1'b0, gt: 1'b0};
            assign lo_key  = '0;
            assign lo_age  = '0;
            assign lo_del  = 1'b0;
        end else begin : g_lo
            assign lo_stat = w_stat[i-1];
            assign lo_key  = w_key[i-1];
            assign lo_age  = w_age[i-1];
            assign lo_del  = w_del[i-1];
        end

        if (i == MAX_WINDOW - 1) begin : g_hi_end
            assign hi_stat = '{valid: 1'b0, gt: 1'b1};
            assign hi_key  = '0;
            assign hi_age  = '0;
        end else begin : g_hi
            assign hi_stat = w_stat[i+1];
            assign hi_key  = w_key[i+1];
            assign hi_age  = w_age[i+1];
        end

        swm_cell #(
            .SAMPLE_W (SAMPLE_WIDTH),
            .AGE_W    (AGE_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_new_key    (new_key),
            .i_oldest_age (r_oldest_age),
            .i_pick       (r_med == AGE_W'(i)),
            .i_lo_stat    (lo_stat),
            .i_lo_key     (lo_key),
            .i_lo_age     (lo_age),
            .i_del_below  (lo_del),
            .i_hi_stat    (hi_stat),
            .i_hi_key     (hi_key),
            .i_hi_age     (hi_age),
            .o_stat       (w_stat[i]),
            .o_key        (w_key[i]),
            .o_age        (w_age[i]),
            .o_del_upto   (w_del[i]),
            .o_tap        (w_tap[i])
        );
    end

    // Only the picked cell drives its tap, so an OR collects the median.
    always_comb begin
        tap_or = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            tap_or = tap_or | w_tap[k];
        end
    end

    // Pending flag and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= (r_pend && !out_free) || (accept && gives_result);
            if (out_free) begin
                r_out_valid <= r_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && out_free) begin
            r_out <= tap_or;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'(r_out);

endmodule

`default_nettype wire

/* sv/swm_checker.sv */
// Port-level checker of the sliding window median filter, bound to the top level.
`default_nettype none
`include "sliding_window_median_defines.svh"

module swm_checker #(
    parameter int TDATA_W = 32
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_s_tvalid,
    input wire logic               o_s_tready,
    input wire logic               o_m_tvalid,
    input wire logic               i_m_tready,
    input wire logic [TDATA_W-1:0] o_m_tdata
);

    // A stalled output word stays offered and unchanged.
    `SWM_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `SWM_ASSERT_NEXT(a_out_stable, o_m_tvalid && !i_m_tready, $stable(o_m_tdata))

    // The input side only stalls while a finished word is blocked at the output.
    `SWM_ASSERT_NOW(a_ready_drop, !o_s_tready, o_m_tvalid && !i_m_tready)

    // A fresh output word always traces back to an earlier word taken at the input.
    `SWM_ASSERT_NOW(a_out_origin, $rose(o_m_tvalid), $past(i_s_tvalid && o_s_tready, 2))

endmodule

bind sliding_window_median swm_checker #(
    .TDATA_W (TDATA_W)
) u_swm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
